// ----- src/tmqc_pkg.sv -----
// Shared types and codes for the timed message queue.
package tmqc_pkg;

    typedef enum logic [2:0] {
        CMD_ENQ      = 3'd0,
        CMD_ENQ_REPL = 3'd1,
        CMD_ENQ_UNIQ = 3'd2,
        CMD_DEQ      = 3'd3,
        CMD_OLDEST   = 3'd4,
        CMD_COUNT    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        OC_INSERTED = 3'd0,
        OC_REPLACED = 3'd1,
        OC_REMOVED  = 3'd2,
        OC_DEQUEUED = 3'd3,
        OC_NONE     = 3'd4,
        OC_OLDEST   = 3'd5,
        OC_COUNT    = 3'd6,
        OC_FULL     = 3'd7
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRIM,
        ST_COPY,
        ST_END
    } state_t;

    typedef struct packed {
        logic [31:0]        code;
        logic signed [63:0] tstamp;
        logic signed [7:0]  prio;
        logic [31:0]        pay;
    } entry_t;

    localparam logic signed [63:0] MAX_STAMP = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [7:0]  EMPTY_PRIO = 8'sd10;

endpackage

// ----- src/timed_message_queue_coalescing.sv -----
// Top level of the timestamp-ordered message queue with coalescing enqueue.
//
// Usage: a command word enters on the input channel (in_valid / in_stall) and
// answers with one or more result words on the output channel (out_valid /
// out_stall); the final word of a command carries last. The table holds up
// to QUEUE_DEPTH messages sorted by time, equal times in arrival order.
// Each command runs a scan pass over the table (one entry per cycle) that
// finds the insertion point, the matching entry and the counts. Commands
// that change the table then run a copy pass that streams the entries from
// one storage bank into the other, inserting, rewriting or dropping entries
// on the way, and the banks swap roles at the end. A query or a command that
// leaves the table as it is ends after its scan pass and result word; in_stall
// is high for the whole command. Removed duplicates are reported during the
// copy pass in table order. When the receiver stalls, the output register
// holds its word and the sequencer waits before it emits the next one. Reset
// empties the table at once; the storage itself is not cleared because only
// entries below the occupancy are ever read.
module timed_message_queue_coalescing #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [31:0]        what_code,
    input  logic               any_what,
    input  logic signed [63:0] stamp,
    input  logic [62:0]        now_time,
    input  logic signed [7:0]  priority_req,
    input  logic [31:0]        payload,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         outcome,
    output logic [31:0]        code_out,
    output logic signed [63:0] stamp_out,
    output logic signed [7:0]  priority_out,
    output logic [31:0]        data_out,
    output logic [5:0]         count_out,
    output logic               more_left,
    output logic               last
);
    import tmqc_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;

    // Latched command word; the stamp is already the effective one.
    logic [2:0]         cmd_reg;
    logic [31:0]        code_reg;
    logic               any_reg;
    logic signed [63:0] st_reg;
    logic signed [7:0]  pr_reg;
    logic [31:0]        data_reg;

    logic [CW-1:0] occ_reg, occ_next;
    logic          cur_reg, cur_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rm_reg, rm_next;
    logic          found_reg, found_next;
    logic          seen_reg, seen_next;
    logic          ins_reg, ins_next;
    entry_t        hit_reg, hit_next;

    // Output register.
    logic               ov_reg, ov_next;
    logic [2:0]         oc_reg, oc_next;
    entry_t             oe_reg, oe_next;
    logic [5:0]         ocnt_reg, ocnt_next;
    logic               omore_reg, omore_next;
    logic               olast_reg, olast_next;

    entry_t rd0, rd1, rd, new_e, wr_data;
    logic   wr_en;
    logic [CW-1:0] wr_addr;
    logic   later_c, eq_c, match_c, out_free, is_full, last_idx;
    logic   prim_copy, adv;
    logic   accept;
    logic signed [63:0] eff_stamp;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign eff_stamp = (stamp == 64'sd0 || stamp[63]) ? $signed({1'b0, now_time}) : stamp;

    tmqc_bank #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_bank0 (
        .clk   (clk),
        .we    (wr_en && cur_reg),
        .waddr (wr_addr[AW-1:0]),
        .wdata (wr_data),
        .raddr (idx_next[AW-1:0]),
        .rdata (rd0)
    );

    tmqc_bank #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_bank1 (
        .clk   (clk),
        .we    (wr_en && !cur_reg),
        .waddr (wr_addr[AW-1:0]),
        .wdata (wr_data),
        .raddr (idx_next[AW-1:0]),
        .rdata (rd1)
    );

    assign rd       = cur_reg ? rd1 : rd0;
    assign later_c  = rd.tstamp > st_reg;
    assign eq_c     = (rd.code == code_reg);
    assign match_c  = eq_c || (any_reg && (cmd_reg == CMD_DEQ || cmd_reg == CMD_COUNT));
    assign out_free = !ov_reg || !out_stall;
    assign is_full  = (occ_reg == CW'(QUEUE_DEPTH));
    assign last_idx = (idx_reg == occ_reg - CW'(1));
    assign new_e    = '{code: code_reg, tstamp: st_reg, prio: pr_reg, pay: data_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (occ_reg == '0) ? ST_PRIM : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = ST_PRIM;
                end
            end
            ST_PRIM:
            begin
                if (out_free)
                begin
                    if (!prim_copy)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = (occ_reg == '0) ? ST_END : ST_COPY;
                    end
                end
            end
            ST_COPY:
            begin
                if (adv && last_idx)
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb
    begin
        occ_next   = occ_reg;
        cur_next   = cur_reg;
        idx_next   = '0;
        w_next     = w_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        rm_next    = rm_reg;
        found_next = found_reg;
        seen_next  = seen_reg;
        ins_next   = ins_reg;
        hit_next   = hit_reg;
        wr_en      = 1'b0;
        wr_addr    = w_reg;
        wr_data    = rd;
        prim_copy  = 1'b0;
        adv        = 1'b0;
        ov_next    = ov_reg && out_stall;
        oc_next    = oc_reg;
        oe_next    = oe_reg;
        ocnt_next  = ocnt_reg;
        omore_next = omore_reg;
        olast_next = olast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    p_next     = '0;
                    n_next     = '0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    seen_next  = 1'b0;
                    ins_next   = 1'b0;
                    w_next     = '0;
                end
            end
            ST_SCAN:
            begin
                idx_next = last_idx ? '0 : idx_reg + CW'(1);
                if (!later_c)
                begin
                    p_next = p_reg + CW'(1);
                end
                else
                begin
                    seen_next = 1'b1;
                end
                if (match_c)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (!found_reg)
                begin
                    priority case (cmd_reg)
                        CMD_ENQ_REPL:
                        begin
                            if (later_c && !seen_reg && eq_c)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        CMD_ENQ_UNIQ:
                        begin
                            if (eq_c && (!later_c || !seen_reg))
                            begin
                                found_next = 1'b1;
                            end
                        end
                        CMD_DEQ:
                        begin
                            found_next = match_c;
                        end
                        CMD_OLDEST:
                        begin
                            found_next = 1'b1;
                        end
                        default:
                        begin
                            found_next = 1'b0;
                        end
                    endcase
                    n_next   = idx_reg;
                    hit_next = rd;
                end
            end
            ST_PRIM:
            begin
                oe_next    = '0;
                ocnt_next  = '0;
                omore_next = 1'b0;
                olast_next = 1'b1;
                rm_next    = cnt_reg - CW'(found_reg);
                priority case (cmd_reg)
                    CMD_ENQ, CMD_ENQ_REPL, CMD_ENQ_UNIQ:
                    begin
                        if ((cmd_reg != CMD_ENQ) && found_reg)
                        begin
                            oc_next = OC_REPLACED;
                            oe_next = '{code: code_reg,
                                        tstamp: (cmd_reg == CMD_ENQ_REPL) ? st_reg
                                                                          : hit_reg.tstamp,
                                        prio: pr_reg, pay: hit_reg.pay};
                            prim_copy = 1'b1;
                        end
                        else if (is_full)
                        begin
                            oc_next = OC_FULL;
                            oe_next = new_e;
                        end
                        else
                        begin
                            oc_next   = OC_INSERTED;
                            oe_next   = new_e;
                            prim_copy = 1'b1;
                            ins_next  = out_free;
                        end
                        if (prim_copy && (cmd_reg != CMD_ENQ))
                        begin
                            olast_next = (rm_next == '0);
                        end
                    end
                    CMD_DEQ:
                    begin
                        if (found_reg)
                        begin
                            oc_next    = OC_DEQUEUED;
                            oe_next    = hit_reg;
                            omore_next = (occ_reg != CW'(1));
                            prim_copy  = 1'b1;
                        end
                        else
                        begin
                            oc_next    = OC_NONE;
                            omore_next = (occ_reg != '0);
                        end
                    end
                    CMD_OLDEST:
                    begin
                        oc_next = OC_OLDEST;
                        if (found_reg)
                        begin
                            oe_next = hit_reg;
                        end
                        else
                        begin
                            oe_next.tstamp = MAX_STAMP;
                            oe_next.prio   = EMPTY_PRIO;
                        end
                    end
                    CMD_COUNT:
                    begin
                        oc_next   = OC_COUNT;
                        ocnt_next = 6'(cnt_reg);
                    end
                    default:
                    begin
                        oc_next = OC_NONE;
                    end
                endcase
                if (out_free)
                begin
                    ov_next = 1'b1;
                end
                else
                begin
                    // The previous command's word is still waiting; keep it intact.
                    oc_next    = oc_reg;
                    oe_next    = oe_reg;
                    ocnt_next  = ocnt_reg;
                    omore_next = omore_reg;
                    olast_next = olast_reg;
                    ins_next   = 1'b0;
                end
            end
            ST_COPY:
            begin
                idx_next = idx_reg;
                if (ins_reg && (idx_reg == p_reg))
                begin
                    // New entry goes in front of the current one.
                    wr_en    = 1'b1;
                    wr_data  = new_e;
                    w_next   = w_reg + CW'(1);
                    ins_next = 1'b0;
                end
                else if (cmd_reg == CMD_DEQ && idx_reg == n_reg)
                begin
                    adv = 1'b1;
                end
                else if ((cmd_reg == CMD_ENQ_REPL || cmd_reg == CMD_ENQ_UNIQ) && eq_c
                         && !(found_reg && idx_reg == n_reg))
                begin
                    if (out_free)
                    begin
                        adv        = 1'b1;
                        ov_next    = 1'b1;
                        oc_next    = OC_REMOVED;
                        oe_next    = rd;
                        ocnt_next  = '0;
                        omore_next = 1'b0;
                        olast_next = (rm_reg == CW'(1));
                        rm_next    = rm_reg - CW'(1);
                    end
                end
                else
                begin
                    adv    = 1'b1;
                    wr_en  = 1'b1;
                    w_next = w_reg + CW'(1);
                    if (found_reg && idx_reg == n_reg)
                    begin
                        wr_data.prio = pr_reg;
                        wr_data.pay  = data_reg;
                        if (cmd_reg == CMD_ENQ_REPL)
                        begin
                            wr_data.tstamp = st_reg;
                        end
                    end
                end
                if (adv)
                begin
                    idx_next = last_idx ? '0 : idx_reg + CW'(1);
                end
            end
            ST_END:
            begin
                if (ins_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = new_e;
                end
                occ_next = w_reg + CW'(ins_reg);
                cur_next = !cur_reg;
                ins_next = 1'b0;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            cur_reg   <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
            ins_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            cur_reg   <= cur_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
            ins_reg   <= ins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            code_reg <= what_code;
            any_reg  <= any_what;
            st_reg   <= eff_stamp;
            pr_reg   <= priority_req;
            data_reg <= payload;
        end
        w_reg     <= w_next;
        p_reg     <= p_next;
        n_reg     <= n_next;
        cnt_reg   <= cnt_next;
        rm_reg    <= rm_next;
        found_reg <= found_next;
        seen_reg  <= seen_next;
        hit_reg   <= hit_next;
        oc_reg    <= oc_next;
        oe_reg    <= oe_next;
        ocnt_reg  <= ocnt_next;
        omore_reg <= omore_next;
        olast_reg <= olast_next;
    end

    assign out_valid    = ov_reg;
    assign outcome      = oc_reg;
    assign code_out     = oe_reg.code;
    assign stamp_out    = oe_reg.tstamp;
    assign priority_out = oe_reg.prio;
    assign data_out     = oe_reg.pay;
    assign count_out    = ocnt_reg;
    assign more_left    = omore_reg;
    assign last         = olast_reg;

endmodule

// ----- src/tmqc_bank.sv -----
// One bank of message storage with a registered read port.
module tmqc_bank #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  tmqc_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output tmqc_pkg::entry_t rdata
);
    import tmqc_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
